>>> sv/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// shared constants, codes and controller/datapath interface types for the
// cave automaton smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_pkg;

  // grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_AW     = $clog2(MAX_WIDTH);
  localparam int ROW_AW     = $clog2(MAX_HEIGHT);
  localparam int UW_W       = $clog2(MAX_WIDTH + 1);
  localparam int UH_W       = $clog2(MAX_HEIGHT + 1);

  // register and field widths
  localparam int DIM_W      = 7;
  localparam int GEN_W      = 4;
  localparam int THR_W      = 4;
  localparam int CNT_W      = 4;
  localparam int OP_W       = 2;
  localparam int COL_FW     = 6;
  localparam int ROW_FW     = 6;
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // operations
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GEN_COUNT   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SURVIVE     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BIRTH       = 3'd4;

  // register reset values
  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 7'd64;
  localparam logic [GEN_W-1:0] GEN_COUNT_RST   = 4'd3;
  localparam logic [THR_W-1:0] SURVIVE_RST     = 4'd3;
  localparam logic [THR_W-1:0] BIRTH_RST       = 4'd5;

  // controller to datapath
  typedef struct packed {
    logic              cap;         // capture input word
    logic              rd_cell;     // read row of the addressed cell
    logic              rd_run;      // read row rd_row for a generation
    logic [ROW_AW-1:0] rd_row;
    logic              run_first;   // load first row, top neighbor is wall
    logic              run_row;     // compute and write back row wr_row
    logic [ROW_AW-1:0] wr_row;
    logic              below_wall;  // bottom neighbor row is wall
    logic              wr_cell;     // write back row with the cell updated
    logic              grab;        // take the addressed cell as read value
    logic              out_load;    // load result register
  } cas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             range_err;
    logic             empty;
    logic [GEN_W-1:0] gen_count;
    logic [UH_W-1:0]  used_h;
  } cas_sts_t;

endpackage

>>> sv/cas_ram.sv
// ----------------------------------------------------------------------------
// cas_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/cas_ctrl.sv
// ----------------------------------------------------------------------------
// cas_ctrl
// sequencer for cell access and generation runs, owns the handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_ctrl
  import cas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  cas_sts_t sts,
  output cas_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CELL   = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_PRIME  = 3'd4;
  localparam logic [2:0] S_ROW    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] y_r, y_nxt;
  logic [GEN_W-1:0]  g_r, g_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              last_row;

  assign last_row = (int'(y_r) == int'(sts.used_h) - 1);

  always_comb begin
    state_nxt = state_r;
    y_nxt     = y_r;
    g_nxt     = g_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op == OP_WRITE || sts.op == OP_READ) begin
          if (sts.range_err) begin
            state_nxt = S_RESP;
          end else begin
            cmd.rd_cell = 1'b1;
            state_nxt   = S_CELL;
          end
        end else if (sts.op == OP_RUN && !sts.empty && sts.gen_count != '0) begin
          g_nxt     = sts.gen_count;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CELL: begin
        if (sts.op == OP_WRITE) begin
          cmd.wr_cell = 1'b1;
        end else begin
          cmd.grab = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_LOAD: begin
        cmd.rd_run = 1'b1;
        cmd.rd_row = '0;
        state_nxt  = S_PRIME;
      end
      S_PRIME: begin
        cmd.run_first = 1'b1;
        cmd.rd_run    = 1'b1;
        cmd.rd_row    = ROW_AW'(1);
        y_nxt         = '0;
        state_nxt     = S_ROW;
      end
      S_ROW: begin
        // row y is written while row y+2 is fetched
        cmd.run_row    = 1'b1;
        cmd.wr_row     = y_r;
        cmd.below_wall = last_row;
        cmd.rd_run     = 1'b1;
        cmd.rd_row     = y_r + ROW_AW'(2);
        if (last_row) begin
          if (g_r == GEN_W'(1)) begin
            state_nxt = S_RESP;
          end else begin
            g_nxt     = g_r - GEN_W'(1);
            state_nxt = S_LOAD;
          end
        end else begin
          y_nxt = y_r + ROW_AW'(1);
        end
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      y_r          <= '0;
      g_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      y_r          <= y_nxt;
      g_r          <= g_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

>>> sv/cas_dpath.sv
// ----------------------------------------------------------------------------
// cas_dpath
// grid memory, row window, neighbor count per row and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_dpath
  import cas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  cas_cmd_t               cmd,
  output cas_sts_t               sts,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // configuration
  logic [DIM_W-1:0] grid_width_r, grid_height_r;
  logic [GEN_W-1:0] gen_count_r;
  logic [THR_W-1:0] survive_r, birth_r;

  // captured word
  logic [OP_W-1:0]   op_r;
  logic [COL_FW-1:0] col_r;
  logic [ROW_FW-1:0] row_r;
  logic              val_r;

  logic [UW_W-1:0] used_w;
  logic [UH_W-1:0] used_h;
  logic            range_err;

  logic [MAX_HEIGHT-1:0] row_vld_r;
  logic                  rd_vld_r;
  logic                  rv_r;
  logic                  out_rv_r, out_st_r;

  logic [MAX_WIDTH-1:0] prev_r, cur_r;
  logic [MAX_WIDTH-1:0] colmask, rd_eff, below, new_row, gen_row, cell_row;
  logic [MAX_WIDTH+1:0] up_x, mid_x, dn_x;
  logic [CNT_W-1:0]     nsum;
  logic [THR_W-1:0]     thr;

  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [COL_AW-1:0] col_idx;
  logic [ROW_AW-1:0] row_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      gen_count_r   <= GEN_COUNT_RST;
      survive_r     <= SURVIVE_RST;
      birth_r       <= BIRTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        CFG_GEN_COUNT:   gen_count_r   <= cfg_wdata[GEN_W-1:0];
        CFG_SURVIVE:     survive_r     <= cfg_wdata[THR_W-1:0];
        CFG_BIRTH:       birth_r       <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_tdata[1:0];
      col_r <= in_tdata[7:2];
      row_r <= in_tdata[13:8];
      val_r <= in_tdata[14];
    end
  end

  // sizes above the maximum saturate
  assign used_w = (int'(grid_width_r) > MAX_WIDTH) ? UW_W'(MAX_WIDTH) : UW_W'(grid_width_r);
  assign used_h = (int'(grid_height_r) > MAX_HEIGHT) ? UH_W'(MAX_HEIGHT)
                                                     : UH_W'(grid_height_r);
  assign range_err = (int'(col_r) >= int'(used_w)) || (int'(row_r) >= int'(used_h));

  assign sts.op        = op_r;
  assign sts.range_err = range_err;
  assign sts.empty     = (used_w == '0) || (used_h == '0);
  assign sts.gen_count = gen_count_r;
  assign sts.used_h    = used_h;

  assign col_idx = COL_AW'(col_r);
  assign row_idx = ROW_AW'(row_r);

  // grid memory, rows never written read as zero
  assign ram_re    = cmd.rd_cell || cmd.rd_run;
  assign ram_raddr = cmd.rd_cell ? row_idx : cmd.rd_row;
  assign ram_we    = cmd.wr_cell || cmd.run_row;
  assign ram_waddr = cmd.wr_cell ? row_idx : cmd.wr_row;
  assign ram_wdata = cmd.wr_cell ? cell_row : gen_row;

  cas_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_grid (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ram_we) begin
      row_vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_r <= row_vld_r[ram_raddr];
    end
  end

  assign rd_eff = rd_vld_r ? ram_rdata : '0;

  always_comb begin
    cell_row          = rd_eff;
    cell_row[col_idx] = val_r;
  end

  // three row window, prev is the old row above
  always_ff @(posedge clk) begin
    if (cmd.run_first) begin
      prev_r <= '1;
      cur_r  <= rd_eff;
    end else if (cmd.run_row) begin
      prev_r <= cur_r;
      cur_r  <= rd_eff;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      colmask[i] = (i < int'(used_w));
    end
  end

  assign below = cmd.below_wall ? '1 : rd_eff;

  // columns outside the grid count as walls
  assign up_x  = {1'b1, prev_r | ~colmask, 1'b1};
  assign mid_x = {1'b1, cur_r  | ~colmask, 1'b1};
  assign dn_x  = {1'b1, below  | ~colmask, 1'b1};

  always_comb begin
    nsum    = '0;
    thr     = '0;
    new_row = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      nsum = CNT_W'(up_x[i]) + CNT_W'(up_x[i+1]) + CNT_W'(up_x[i+2])
           + CNT_W'(mid_x[i]) + CNT_W'(mid_x[i+2])
           + CNT_W'(dn_x[i]) + CNT_W'(dn_x[i+1]) + CNT_W'(dn_x[i+2]);
      thr  = cur_r[i] ? survive_r : birth_r;
      new_row[i] = (nsum >= thr);
    end
  end

  // cells beyond the configured width keep their value
  assign gen_row = (new_row & colmask) | (cur_r & ~colmask);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rv_r <= 1'b0;
    end else if (cmd.grab) begin
      rv_r <= rd_eff[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rv_r <= rv_r;
      out_st_r <= range_err && (op_r == OP_WRITE || op_r == OP_READ);
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-2){1'b0}}, out_st_r, out_rv_r};

endmodule

>>> sv/cave_automaton_smoother.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoother: binary grid with cave smoothing generations
// cell write or read: accept, decode, cell access, result; flagged or unused word:
// accept, decode, result; run: G generations of H rows, one row per cycle on the
// grid memory read and write ports; one word in work at a time
// sync reset: registers to defaults, all grid rows read as zero via row flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cave_automaton_smoother
  import cas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] operation, [7:2] column, [13:8] row, [14] cell_value, [15] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] read_value, [1] status, [7:2] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cas_cmd_t cmd;
  cas_sts_t sts;

  cas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cas_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_tdata(out_tdata)
  );

`ifndef SYNTH
  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in work");

  // cell write back only right after its row read
  a_cell_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_cell |-> $past(cmd.rd_cell))
    else $error("cell write without row read");

  // row compute needs a primed window
  a_row_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_row |-> ($past(cmd.run_first) || $past(cmd.run_row)))
    else $error("row computed without window");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result load not visible");
`endif

endmodule

>>> dv/tb_cave_automaton_smoother.sv
// ----------------------------------------------------------------------------
// tb_cave_automaton_smoother
// Self-checking bench for the cave smoothing grid. It holds its own copy of the
// grid and the five registers and predicts one reply word for every command.
// Directed commands hit the grid corners, empty and saturated sizes, threshold
// and generation extremes, and the unused opcode. Random phases then set up a
// grid, fill it, run generations and read cells back. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cave_automaton_smoother;
  import cas_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int MAX_IDLE    = 12;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  // opcode with no function, answered with an all-zero reply
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic read_value;
    logic status;
  } cell_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IW-1:0]      cfg_index = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [1:0] operation, [7:2] column, [13:8] row, [14] cell_value, [15] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] read_value, [1] status, [7:2] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predicted grid and register copies
  logic [MAX_WIDTH-1:0] cave_cells [MAX_HEIGHT];
  logic [DIM_W-1:0]     grid_cols;
  logic [DIM_W-1:0]     grid_rows;
  logic [GEN_W-1:0]     gen_total;
  logic [THR_W-1:0]     keep_level;
  logic [THR_W-1:0]     born_level;

  cell_reply_t pending_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  bit          burst_mode = 1'b0;

  cave_automaton_smoother i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic void clear_cave();
    for (int y = 0; y < MAX_HEIGHT; y++) cave_cells[y] = '0;
    grid_cols  = GRID_WIDTH_RST;
    grid_rows  = GRID_HEIGHT_RST;
    gen_total  = GEN_COUNT_RST;
    keep_level = SURVIVE_RST;
    born_level = BIRTH_RST;
  endfunction

  function automatic int used_cols();
    return (grid_cols > MAX_WIDTH) ? MAX_WIDTH : int'(grid_cols);
  endfunction

  function automatic int used_rows();
    return (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_rows);
  endfunction

  // positions off the used grid count as solid
  function automatic int solid_neighbours(int x, int y, int w, int h);
    int n, nx, ny;
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        ny = y + dy;
        if (dx != 0 || dy != 0) begin
          if (nx >= 0 && nx < w && ny >= 0 && ny < h) n += cave_cells[ny][nx];
          else n++;
        end
      end
    end
    return n;
  endfunction

  function automatic void smooth_cave();
    logic [MAX_WIDTH-1:0] fresh [MAX_HEIGHT];
    int w, h, n, level;
    w = used_cols();
    h = used_rows();
    for (int g = 0; g < int'(gen_total); g++) begin
      for (int y = 0; y < MAX_HEIGHT; y++) fresh[y] = cave_cells[y];
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          n = solid_neighbours(x, y, w, h);
          level = cave_cells[y][x] ? int'(keep_level) : int'(born_level);
          fresh[y][x] = (n >= level);
        end
      end
      for (int y = 0; y < MAX_HEIGHT; y++) cave_cells[y] = fresh[y];
    end
  endfunction

  function automatic cell_reply_t predict_reply(logic [OP_W-1:0] op, logic [COL_FW-1:0] col,
                                                logic [ROW_FW-1:0] row, logic val);
    cell_reply_t r;
    r = '0;
    if (op == OP_WRITE || op == OP_READ) begin
      if (int'(col) >= used_cols() || int'(row) >= used_rows()) r.status = 1'b1;
      else if (op == OP_WRITE) cave_cells[row][col] = val;
      else r.read_value = cave_cells[row][col];
    end else if (op == OP_RUN) begin
      smooth_cave();
    end
    return r;
  endfunction

  task automatic send_cell_cmd(input logic [OP_W-1:0] op, input int col, input int row,
                               input logic val);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, row[ROW_FW-1:0], col[COL_FW-1:0], op};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(predict_reply(op, col[COL_FW-1:0], row[ROW_FW-1:0], val));
    items_sent++;
  endtask

  // unused opcode or coordinates anywhere in the field range
  task automatic send_stray_cmd();
    logic [OP_W-1:0] op;
    case ($urandom_range(0, 2))
      0:       op = OP_WRITE;
      1:       op = OP_READ;
      default: op = OP_UNUSED;
    endcase
    send_cell_cmd(op, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
  endtask

  task automatic wait_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  grid_cols  = value[DIM_W-1:0];
      CFG_GRID_HEIGHT: grid_rows  = value[DIM_W-1:0];
      CFG_GEN_COUNT:   gen_total  = value[GEN_W-1:0];
      CFG_SURVIVE:     keep_level = value[THR_W-1:0];
      CFG_BIRTH:       born_level = value[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cave_setup(input int w, input int h, input int gens, input int keep,
                            input int born);
    wait_replies();
    cfg_write(CFG_GRID_WIDTH, w);
    cfg_write(CFG_GRID_HEIGHT, h);
    cfg_write(CFG_GEN_COUNT, gens);
    cfg_write(CFG_SURVIVE, keep);
    cfg_write(CFG_BIRTH, born);
  endtask

  // mostly small grids so runs stay short, a few empty or oversized ones
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 8) return $urandom_range(MAX_WIDTH + 1, 127);
    if (r < 14) return MAX_WIDTH;
    if (r < 24) return $urandom_range(13, MAX_WIDTH - 1);
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_level();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 15);
  endfunction

  // defaults: corners, unused opcode, one run on the full grid
  task automatic test_cell_access();
    send_cell_cmd(OP_WRITE, 0, 0, 1'b1);
    send_cell_cmd(OP_WRITE, 63, 63, 1'b1);
    send_cell_cmd(OP_WRITE, 0, 63, 1'b1);
    send_cell_cmd(OP_READ, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 63, 63, 1'b0);
    send_cell_cmd(OP_READ, 63, 0, 1'b0);
    send_cell_cmd(OP_UNUSED, 63, 63, 1'b1);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 1, 0, 1'b0);
  endtask

  task automatic test_config_edges();
    // single cell, coordinates just past each edge, everything survives
    cave_setup(1, 1, 1, 0, 0);
    send_cell_cmd(OP_WRITE, 0, 0, 1'b1);
    send_cell_cmd(OP_READ, 1, 0, 1'b0);
    send_cell_cmd(OP_READ, 0, 1, 1'b0);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 0, 0, 1'b0);
    // empty grid flags every access
    cave_setup(0, 64, 3, 3, 5);
    send_cell_cmd(OP_WRITE, 0, 0, 1'b1);
    send_cell_cmd(OP_READ, 0, 0, 1'b0);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    // saturated sizes, thresholds never met, longest run
    cave_setup(127, 100, 15, 9, 15);
    send_cell_cmd(OP_WRITE, 62, 63, 1'b1);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 62, 63, 1'b0);
    // zero generations leave the grid alone
    cave_setup(64, 2, 0, 8, 0);
    send_cell_cmd(OP_WRITE, 5, 1, 1'b1);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 5, 1, 1'b0);
    // birth always met
    cave_setup(3, 2, 15, 8, 0);
    send_cell_cmd(OP_RUN, 0, 0, 1'b0);
    send_cell_cmd(OP_READ, 2, 1, 1'b0);
  endtask

  task automatic random_cave_phase();
    int uw, uh, cells, rounds, fills, reads, density, x, y;
    cave_setup(pick_dim(), pick_dim(), $urandom_range(0, 15), pick_level(), pick_level());
    burst_mode = ($urandom_range(0, 3) == 0);
    uw = used_cols();
    uh = used_rows();
    cells = uw * uh;
    rounds = $urandom_range(1, 3);
    for (int r = 0; r < rounds; r++) begin
      density = $urandom_range(15, 85);
      fills = (cells <= 64) ? cells : $urandom_range(16, 48);
      if (r > 0) fills = (fills + 3) / 4;
      for (int i = 0; i < fills; i++) begin
        if (cells <= 64) begin
          x = i % uw;
          y = i / uw;
        end else begin
          x = $urandom_range(0, uw - 1);
          y = $urandom_range(0, uh - 1);
        end
        send_cell_cmd(OP_WRITE, x, y, $urandom_range(0, 99) < density);
        if ($urandom_range(0, 9) == 0) send_stray_cmd();
      end
      send_cell_cmd(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      reads = (cells < 24) ? cells : 24;
      for (int i = 0; i < reads; i++) begin
        send_cell_cmd(OP_READ, $urandom_range(0, uw - 1), $urandom_range(0, uh - 1),
                      $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) send_stray_cmd();
      end
      if (cells == 0) begin
        for (int i = 0; i < 4; i++) send_stray_cmd();
      end
      // hold the sender until the block has answered everything
      if ($urandom_range(0, 3) == 0) wait_replies();
    end
  endtask

  task automatic test_random_caves();
    while (items_sent < ITEM_TARGET) random_cave_phase();
  endtask

  always @(posedge clk) begin : check_replies
    cell_reply_t want;
    if (out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reply word %h at %0t", out_tdata, $realtime);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[0] !== want.read_value || out_tdata[1] !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("reply mismatch at %0t: read_value exp %0b got %0b, status exp %0b got %0b",
                     $realtime, want.read_value, out_tdata[0], want.status, out_tdata[1]);
        end
      end
    end
  end

  initial begin : sink_replies
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    clear_cave();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_access();
    test_config_edges();
    test_random_caves();
    wait_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/cas_pkg.sv
sv/cas_ram.sv
sv/cas_ctrl.sv
sv/cas_dpath.sv
sv/cave_automaton_smoother.sv
dv/tb_cave_automaton_smoother.sv
